FILE: rtl/core/mms_pkg.sv
package mms_pkg;

    // Register file geometry.
    localparam int REG_COUNT = 32;
    localparam int ADDR_W    = $clog2(REG_COUNT);
    localparam int DATA_W    = 16;
    localparam int PHY_W     = 5;

    // Preamble counter and frame phase.
    localparam int          PRE_W      = 8;
    localparam logic [7:0]  PRE_MAX    = 8'd128;
    localparam logic [7:0]  PRE_SYNC   = 8'd32;
    localparam int          PHASE_W    = 5;
    localparam logic [4:0]  PHASE_LAST = 5'd16;

    // Frame shifter constants.
    localparam logic [31:0] SHIFT_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] LOAD_MASK  = 32'h8000_7FFF;
    localparam int          TA_BIT     = 15;
    localparam int          ERR_BIT    = 16;
    localparam int          DRIVE_BIT  = 30;
    localparam int          LOAD_SHIFT = 15;

    // Clause-22 opcodes, including the two start bits.
    localparam logic [3:0]  OP_READ    = 4'h6;
    localparam logic [3:0]  OP_WRITE   = 4'h5;

    // Configuration register indexes.
    localparam logic        CFG_PHY_ADDR  = 1'b0;
    localparam logic        CFG_MIN_TICKS = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] peek_index;
        logic              mdio_in;
        logic              mdc;
        logic              reset_request;
    } t_item;

    typedef struct packed {
        logic              write_format_error;
        logic [DATA_W-1:0] peek_value;
        logic              mdio_out;
    } t_result;

    typedef struct packed {
        logic rst;
        logic rise;
        logic fall;
        logic sync_load;
        logic synced;
    } t_clk_stat;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_wr;

endpackage

FILE: rtl/core/mms_clkmon.sv
module mms_clkmon #(
    parameter int TICK_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  mms_pkg::t_item     i_item,
    input  logic [15:0]        i_min_ticks,
    output mms_pkg::t_clk_stat o_stat
);
    import mms_pkg::*;

    localparam int CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

    logic                  r_prev, n_prev;
    logic [TICK_WIDTH-1:0] r_tick, n_tick;
    logic [TICK_WIDTH-1:0] r_last, n_last;
    logic [PRE_W-1:0]      r_pre, n_pre;
    logic                  r_synced, n_synced;

    logic [TICK_WIDTH-1:0] w_tick_inc;
    logic                  w_rise;
    logic                  w_fall;
    logic                  w_bad;

    always_comb begin
        w_tick_inc = (r_tick == {TICK_WIDTH{1'b1}}) ? r_tick : r_tick + TICK_WIDTH'(1);
        w_rise     = i_item.mdc & ~r_prev & ~i_item.reset_request;
        w_fall     = ~i_item.mdc & r_prev & ~i_item.reset_request;
        w_bad      = (w_tick_inc != r_last) || (CMP_W'(r_last) < CMP_W'(i_min_ticks));

        n_prev   = i_item.mdc;
        n_tick   = w_tick_inc;
        n_last   = r_last;
        n_pre    = r_pre;
        n_synced = r_synced;

        if (i_item.reset_request) begin
            n_pre    = '0;
            n_synced = 1'b0;
        end else if (w_rise) begin
            if (i_item.mdio_in && r_pre < PRE_MAX) begin
                n_pre = r_pre + PRE_W'(1);
            end else if (!i_item.mdio_in) begin
                n_pre = '0;
            end
            // A period that changed, or one that is too short, breaks sync.
            if (w_bad) begin
                n_pre    = '0;
                n_synced = 1'b0;
            end
            n_last = w_tick_inc;
            n_tick = '0;
        end

        o_stat.rst       = i_item.reset_request;
        o_stat.rise      = w_rise;
        o_stat.fall      = w_fall;
        o_stat.sync_load = ~i_item.reset_request & (n_pre > PRE_SYNC);
        if (o_stat.sync_load) begin
            n_synced = 1'b1;
        end
        o_stat.synced    = n_synced;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b0;
            r_tick   <= '0;
            r_last   <= '0;
            r_pre    <= '0;
            r_synced <= 1'b0;
        end else if (i_fire) begin
            r_prev   <= n_prev;
            r_tick   <= n_tick;
            r_last   <= n_last;
            r_pre    <= n_pre;
            r_synced <= n_synced;
        end
    end

endmodule

FILE: rtl/core/mms_frame.sv
module mms_frame (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  mms_pkg::t_item             i_item,
    input  mms_pkg::t_clk_stat         i_stat,
    input  logic [mms_pkg::PHY_W-1:0]  i_phy_addr,
    input  logic [mms_pkg::DATA_W-1:0] i_rd_data,
    output logic [mms_pkg::ADDR_W-1:0] o_rd_addr,
    output mms_pkg::t_wr               o_wr,
    output logic                       o_mdio_out,
    output logic                       o_err
);
    import mms_pkg::*;

    logic [31:0]        r_si, n_si;
    logic [31:0]        r_so, n_so;
    logic [PHASE_W-1:0] r_ph, n_ph;

    logic [31:0]        w_si_a;
    logic [PHASE_W-1:0] w_ph_a;
    logic [31:0]        w_sh;

    always_comb begin
        // A preamble long enough to sync restarts frame capture.
        w_si_a = i_stat.sync_load ? SHIFT_ONES : r_si;
        w_ph_a = i_stat.sync_load ? '0 : r_ph;
        w_sh   = {w_si_a[30:0], i_item.mdio_in};

        n_si       = r_si;
        n_so       = r_so;
        n_ph       = r_ph;
        o_wr       = '0;
        o_err      = 1'b0;
        o_mdio_out = 1'b1;

        if (i_stat.rst) begin
            n_si = SHIFT_ONES;
        end else begin
            n_si = w_si_a;
            n_ph = w_ph_a;
            if (i_stat.rise && i_stat.synced) begin
                n_si = w_sh;
                if (w_ph_a == '0 && !w_sh[TA_BIT]) begin
                    // Header complete: start, opcode, PHY and register address.
                    n_ph = PHASE_W'(1);
                    if (w_sh[15:12] == OP_READ && w_sh[11:7] == i_phy_addr) begin
                        n_so = LOAD_MASK | (32'(i_rd_data) << LOAD_SHIFT);
                    end
                end else if (w_ph_a != '0 && w_ph_a < PHASE_LAST) begin
                    n_ph = w_ph_a + PHASE_W'(1);
                end else if (w_ph_a != '0) begin
                    n_ph = '0;
                    n_si = SHIFT_ONES;
                    if (w_sh[31:28] == OP_WRITE && w_sh[27:23] == i_phy_addr) begin
                        o_wr.we   = i_fire;
                        o_wr.addr = w_sh[22:18];
                        o_wr.data = w_sh[DATA_W-1:0];
                        o_err     = w_sh[ERR_BIT];
                    end
                end
            end else if (i_stat.fall) begin
                n_so = {r_so[30:0], 1'b1};
            end
            o_mdio_out = i_item.mdio_in & n_so[DRIVE_BIT];
        end

        // A read header always takes its address from these bits of the
        // shifter as it stands before the item that completes the header.
        o_rd_addr = n_si[ADDR_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_si <= SHIFT_ONES;
            r_so <= SHIFT_ONES;
            r_ph <= '0;
        end else if (i_fire) begin
            r_si <= n_si;
            r_so <= n_so;
            r_ph <= n_ph;
        end
    end

endmodule

FILE: rtl/core/mms_regfile.sv
module mms_regfile (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mms_pkg::t_wr               i_wr,
    input  logic                       i_op_re,
    input  logic [mms_pkg::ADDR_W-1:0] i_op_addr,
    output logic [mms_pkg::DATA_W-1:0] o_op_data,
    input  logic                       i_pk_re,
    input  logic [mms_pkg::ADDR_W-1:0] i_pk_addr,
    output logic [mms_pkg::DATA_W-1:0] o_pk_data
);
    import mms_pkg::*;

    logic [DATA_W-1:0]    r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;

    logic [DATA_W-1:0] r_op_q, r_op_wd;
    logic [DATA_W-1:0] r_pk_q, r_pk_wd;
    logic              r_op_hit, r_op_vld;
    logic              r_pk_hit, r_pk_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_op_re) begin
            r_op_q  <= r_mem[i_op_addr];
            r_op_wd <= i_wr.data;
        end
        if (i_pk_re) begin
            r_pk_q  <= r_mem[i_pk_addr];
            r_pk_wd <= i_wr.data;
        end
    end

    // Entries never written read as zero; a write in the read cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_op_hit <= 1'b0;
            r_op_vld <= 1'b0;
            r_pk_hit <= 1'b0;
            r_pk_vld <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_op_re) begin
                r_op_hit <= i_wr.we && (i_wr.addr == i_op_addr);
                r_op_vld <= r_valid[i_op_addr];
            end
            if (i_pk_re) begin
                r_pk_hit <= i_wr.we && (i_wr.addr == i_pk_addr);
                r_pk_vld <= r_valid[i_pk_addr];
            end
        end
    end

    assign o_op_data = r_op_hit ? r_op_wd : (r_op_vld ? r_op_q : '0);
    assign o_pk_data = r_pk_hit ? r_pk_wd : (r_pk_vld ? r_pk_q : '0);

endmodule

FILE: rtl/core/mdio_management_slave.sv
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+------------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | one oversampled MDC/MDIO tick
// m_axis    | out       | m_axis_tvalid / m_axis_tready | resolved line, peek word, error flag
// cfg       | in        | i_cfg_valid / o_cfg_ready     | register index and write data
//
// Every item passes through the input register and then the result register,
// and a new item is taken in every cycle unless the result register is full
// and not taken. This rate is set by the state update of the clock monitor
// and frame shifter, which each item needs in turn.
// Reset (i_rst_n low, synchronous) clears the valid flags, the line state and
// the register file; the register file needs no clearing pass.
// The input side stalls only while the result register is full and not taken.
module mdio_management_slave #(
    parameter int TICK_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] reset_request, [1] mdc, [2] mdio_in, [7:3] peek_index
    input  logic [7:0]  s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] mdio_out, [16:1] peek_value, [17] write_format_error, [23:18] zero
    output logic [23:0] m_axis_tdata,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mms_pkg::*;

    // Configuration registers. Write them only while the block is idle; the block does not enforce it.
    logic [PHY_W-1:0] r_phy_addr;
    logic [15:0]      r_min_ticks;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phy_addr  <= PHY_W'(1);
            r_min_ticks <= 16'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PHY_ADDR:  r_phy_addr  <= i_cfg_data[PHY_W-1:0];
                CFG_MIN_TICKS: r_min_ticks <= i_cfg_data;
                default:       r_phy_addr  <= r_phy_addr;
            endcase
        end
    end

    // Input register and result register. The item in the input register is
    // processed (and the line state updated) when the result register can
    // take its result.
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    w_fire;
    logic    w_accept;

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    t_clk_stat         w_stat;
    t_wr               w_wr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;
    logic [DATA_W-1:0] w_pk_data;
    logic              w_mdio_out;
    logic              w_err;
    t_result           w_result;

    mms_clkmon #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_clkmon (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in),
        .i_min_ticks (r_min_ticks),
        .o_stat      (w_stat)
    );

    mms_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_item     (r_in),
        .i_stat     (w_stat),
        .i_phy_addr (r_phy_addr),
        .i_rd_data  (w_rd_data),
        .o_rd_addr  (w_rd_addr),
        .o_wr       (w_wr),
        .o_mdio_out (w_mdio_out),
        .o_err      (w_err)
    );

    // The read port for read frames is fetched one item ahead, at the shifter
    // position the next item will see. The peek port is fetched when the item
    // is accepted; a write by the item itself is merged below.
    mms_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_op_re   (w_fire),
        .i_op_addr (w_rd_addr),
        .o_op_data (w_rd_data),
        .i_pk_re   (w_accept),
        .i_pk_addr (s_axis_tdata[7:3]),
        .o_pk_data (w_pk_data)
    );

    always_comb begin
        w_result.mdio_out           = w_mdio_out;
        w_result.write_format_error = w_err;
        w_result.peek_value         = (w_wr.we && w_wr.addr == r_in.peek_index)
                                      ? w_wr.data : w_pk_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= t_item'(s_axis_tdata);
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out};

endmodule

FILE: rtl/core/mms_checker.sv
module mms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The input side stalls only behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // After an accepted item has passed the input and result registers, a result must be valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("result missing after accepted item");

    // A newly raised result always traces back to an item accepted through the input register.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a source item");

endmodule

bind mdio_management_slave mms_checker u_mms_checker (.*);
